>>> design/nbd_pkg.sv
// nbd_pkg: shared types, constants and the header text table for the news batch deframer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package nbd_pkg;

  localparam int LengthBits = 32;
  localparam int OffsetBits = 32;
  localparam int QueueDepth = 4;
  localparam int MaxResults = 3;

  localparam logic [3:0] HdrLen     = 4'd9;
  localparam logic [3:0] MatchBlank = 4'd10;

  localparam logic [7:0] CharHash  = 8'h23;
  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_BLANKS,
    PH_DIGITS,
    PH_BODY,
    PH_BOUNDARY,
    PH_DISCARD
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_END     = 2'd1,
    KIND_CORRUPT = 2'd2,
    KIND_DONE    = 2'd3
  } kind_e;

  // all results caused by one input byte
  typedef struct packed {
    logic [1:0]                            cnt;
    logic [7:0]                            data;
    logic [MaxResults-1:0][1:0]            kind;
    logic [MaxResults-1:0][OffsetBits-1:0] offset;
  } job_t;

  function automatic logic [7:0] hdr_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h23;
      4'd1:    c = 8'h21;
      4'd2:    c = 8'h20;
      4'd3:    c = 8'h72;
      4'd4:    c = 8'h6E;
      4'd5:    c = 8'h65;
      4'd6:    c = 8'h77;
      4'd7:    c = 8'h73;
      4'd8:    c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> design/nbd_ifs.sv
// nbd_ifs: valid/ready channel interfaces for input bytes, results and configuration
// depends on nbd_pkg for field widths
`timescale 1ns / 1ps

interface nbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_file;

  modport source (output valid, byte_in, end_of_file, input ready);
  modport sink (input valid, byte_in, end_of_file, output ready);
endinterface

interface nbd_out_if;
  import nbd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [7:0]            data_byte;
  logic [OffsetBits-1:0] file_offset;
  logic                  last_of_run;

  modport source (output valid, kind, data_byte, file_offset, last_of_run, input ready);
  modport sink (input valid, kind, data_byte, file_offset, last_of_run, output ready);
endinterface

interface nbd_cfg_if;
  logic valid;
  logic ready;
  logic filter_cr;

  modport source (output valid, filter_cr, input ready);
  modport sink (input valid, filter_cr, output ready);
endinterface

>>> design/nbd_front.sv
// nbd_front: accepts bytes, runs the header/length/body parser and builds one job per byte
// depends on nbd_pkg and nbd_ifs
`timescale 1ns / 1ps

module nbd_front
  import nbd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  nbd_in_if.sink       in_i,
  nbd_cfg_if.sink      cfg_i,
  input  logic         full_i,
  output logic         push_o,
  output job_t         job_o
);

  phase_e                phase_q, phase_d;
  logic [3:0]            match_q, match_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic [LengthBits-1:0] left_q, left_d;
  logic [OffsetBits-1:0] off_q, off_d;
  logic [OffsetBits-1:0] art_q, art_d;
  logic                  filter_q;

  logic                  fire;
  logic                  is_digit;
  logic [LengthBits+3:0] prod;
  logic                  ovf;
  logic [3:0]            idx;
  logic [3:0]            nxt;
  logic [1:0]            n;
  logic [OffsetBits-1:0] off_inc;
  job_t                  job;

  assign in_i.ready = !full_i;
  assign cfg_i.ready = 1'b1;
  assign fire = in_i.valid && in_i.ready;
  assign push_o = fire && (job.cnt != 2'd0);
  assign job_o = job;
  assign off_inc = off_q + {{(OffsetBits-1){1'b0}}, 1'b1};

  assign is_digit = (in_i.byte_in >= CharZero) && (in_i.byte_in <= CharNine);
  // accum * 10 + digit with room for overflow
  assign prod = ({4'd0, len_q} << 3) + ({4'd0, len_q} << 1)
              + {{LengthBits{1'b0}}, in_i.byte_in[3:0]};
  assign ovf = |prod[LengthBits+3:LengthBits];

  always_comb begin
    phase_d = phase_q;
    match_d = match_q;
    len_d   = len_q;
    left_d  = left_q;
    off_d   = off_q;
    art_d   = art_q;
    job     = '0;
    n       = 2'd0;
    idx     = (match_q >= HdrLen) ? 4'd0 : match_q;
    nxt     = idx + 4'd1;
    if (fire) begin
      case (phase_q)
        PH_HEADER: begin
          if (in_i.byte_in == hdr_char(idx)) begin
            match_d = nxt;
            if (nxt == HdrLen) begin
              phase_d = PH_BLANKS;
              len_d   = '0;
            end
          end else begin
            job.kind[0]   = KIND_CORRUPT;
            job.offset[0] = off_q;
            n             = 2'd1;
            phase_d       = PH_DISCARD;
          end
        end
        PH_BLANKS: begin
          if (in_i.byte_in == CharSpace || in_i.byte_in == CharTab) begin
            match_d = MatchBlank;
          end else if (is_digit) begin
            len_d   = {{(LengthBits-4){1'b0}}, in_i.byte_in[3:0]};
            phase_d = PH_DIGITS;
          end else if (in_i.byte_in == CharNl && match_q == HdrLen) begin
            art_d   = off_inc;
            left_d  = '0;
            len_d   = '0;
            phase_d = PH_BOUNDARY;
          end else begin
            job.kind[0]   = KIND_CORRUPT;
            job.offset[0] = off_q;
            n             = 2'd1;
            phase_d       = PH_DISCARD;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            if (ovf) begin
              job.kind[0]   = KIND_CORRUPT;
              job.offset[0] = off_q;
              n             = 2'd1;
              phase_d       = PH_DISCARD;
            end else begin
              len_d = prod[LengthBits-1:0];
            end
          end else if (in_i.byte_in == CharNl) begin
            art_d   = off_inc;
            left_d  = len_q;
            len_d   = '0;
            phase_d = (len_q == '0) ? PH_BOUNDARY : PH_BODY;
          end else begin
            job.kind[0]   = KIND_CORRUPT;
            job.offset[0] = off_q;
            n             = 2'd1;
            phase_d       = PH_DISCARD;
          end
        end
        PH_BODY: begin
          if (!(filter_q && in_i.byte_in == CharCr)) begin
            job.kind[0]   = KIND_BYTE;
            job.data      = in_i.byte_in;
            job.offset[0] = art_q;
            n             = 2'd1;
          end
          left_d = left_q - {{(LengthBits-1){1'b0}}, 1'b1};
          if (left_q == {{(LengthBits-1){1'b0}}, 1'b1}) begin
            phase_d = PH_BOUNDARY;
          end
        end
        PH_BOUNDARY: begin
          if (in_i.byte_in == CharHash) begin
            job.kind[0]   = KIND_END;
            job.offset[0] = art_q;
            n             = 2'd1;
            phase_d       = PH_HEADER;
            match_d       = 4'd1;
          end else begin
            job.kind[0]   = KIND_CORRUPT;
            job.offset[0] = off_q;
            n             = 2'd1;
            phase_d       = PH_DISCARD;
          end
        end
        default: begin
          phase_d = PH_DISCARD;
        end
      endcase

      if (in_i.end_of_file) begin
        if (phase_d == PH_BOUNDARY) begin
          job.kind[n]   = KIND_END;
          job.offset[n] = art_d;
          n             = n + 2'd1;
        end else if (phase_d != PH_DISCARD) begin
          job.kind[n]   = KIND_CORRUPT;
          job.offset[n] = off_inc;
          n             = n + 2'd1;
        end
        job.kind[n]   = KIND_DONE;
        job.offset[n] = off_inc;
        n             = n + 2'd1;
        phase_d = PH_HEADER;
        match_d = 4'd0;
        len_d   = '0;
        left_d  = '0;
        off_d   = '0;
        art_d   = '0;
      end else begin
        off_d = off_inc;
      end
      job.cnt = n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      match_q  <= 4'd0;
      len_q    <= '0;
      left_q   <= '0;
      off_q    <= '0;
      art_q    <= '0;
      filter_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      match_q <= match_d;
      len_q   <= len_d;
      left_q  <= left_d;
      off_q   <= off_d;
      art_q   <= art_d;
      if (cfg_i.valid && cfg_i.ready) begin
        filter_q <= cfg_i.filter_cr;
      end
    end
  end

  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> job.cnt != 2'd0)
    else $error("job pushed with no results");

  a_eof_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_i.end_of_file |=> off_q == '0 && phase_q == PH_HEADER)
    else $error("state not cleared after end of file");

  a_discard_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && phase_q == PH_DISCARD && !in_i.end_of_file |-> !push_o)
    else $error("result produced while discarding");

endmodule

>>> design/nbd_queue.sv
// nbd_queue: short job queue between parser and result sequencer
// depends on nbd_pkg for job_t and depth
`timescale 1ns / 1ps

module nbd_queue
  import nbd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  localparam int PtrBits = $clog2(QueueDepth);
  localparam int CntBits = $clog2(QueueDepth + 1);

  job_t               mem [QueueDepth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [CntBits-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntBits'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + PtrBits'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntBits'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntBits'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(QueueDepth))
    else $error("queue count out of range");

endmodule

>>> design/nbd_back.sv
// nbd_back: walks the results of each queued job and drives the output register
// depends on nbd_pkg and nbd_ifs
`timescale 1ns / 1ps

module nbd_back
  import nbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  job_t      head_i,
  output logic      pop_o,
  nbd_out_if.source out_o
);

  logic                  valid_q;
  logic [1:0]            kind_q;
  logic [7:0]            data_q;
  logic [OffsetBits-1:0] offset_q;
  logic                  last_q;
  logic [1:0]            sub_q, sub_d;
  logic                  load, issue, is_last;

  assign load    = !valid_q || out_o.ready;
  assign issue   = load && !empty_i;
  assign is_last = (sub_q == head_i.cnt - 2'd1);
  assign pop_o   = issue && is_last;

  always_comb begin
    sub_d = sub_q;
    if (issue) begin
      sub_d = is_last ? 2'd0 : sub_q + 2'd1;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.kind        = kind_q;
  assign out_o.data_byte   = data_q;
  assign out_o.file_offset = offset_q;
  assign out_o.last_of_run = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sub_q   <= 2'd0;
    end else begin
      sub_q <= sub_d;
      if (load) begin
        valid_q <= !empty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      kind_q   <= head_i.kind[sub_q];
      data_q   <= (head_i.kind[sub_q] == KIND_BYTE) ? head_i.data : 8'd0;
      offset_q <= head_i.offset[sub_q];
      last_q   <= is_last;
    end
  end

  a_sub_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> sub_q < head_i.cnt)
    else $error("result index beyond job size");

endmodule

>>> design/news_batch_deframer_top.sv
// news_batch_deframer_top: news batch file deframer, parser front, job queue, result back
// depends on nbd_pkg, nbd_ifs, nbd_front, nbd_queue, nbd_back
//
// channel  dir  payload                                            request when
// in_i     in   byte_in[7:0], end_of_file                          valid && ready
// cfg_i    in   filter_cr                                          valid && ready
// out_o    out  kind[1:0], data_byte[7:0], file_offset[31:0],      valid && ready
//               last_of_run
//
// one input byte per cycle while the queue is not full; the parser is a single-cycle state update
// a byte can give up to 3 results (more than one only at end of file), sent to the output one at a time
// a 4-entry job queue lets the input run while the output register is stalled
// ready on in_i drops only when the queue is full; cfg_i is always ready
// reset clears parser state, queue and output register; no clearing pass
`timescale 1ns / 1ps

module news_batch_deframer_top
  import nbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  nbd_in_if.sink    in_i,
  nbd_cfg_if.sink   cfg_i,
  nbd_out_if.source out_o
);

  logic push, full, pop, empty;
  job_t job, head;

  nbd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job)
  );

  nbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head)
  );

  nbd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
